// File: rtl/core/key_debounce_long_press_repeat_core_macros.svh
// ---------------------------------------------------------------------------
// key debounce core assertion macros
// shared concurrent assertion forms, clocked on clk with synchronous reset
// ---------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_LONG_PRESS_REPEAT_CORE_MACROS_SVH
`define KEY_DEBOUNCE_LONG_PRESS_REPEAT_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define KDLPR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdlpr same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define KDLPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdlpr next-cycle check failed");

`endif

// File: rtl/core/kdlpr_pkg.sv
// ---------------------------------------------------------------------------
// kdlpr_pkg
// types and constants shared by the key debounce lanes, merge and top level
// ---------------------------------------------------------------------------
package kdlpr_pkg;

  // widths fixed by the register and field definitions
  localparam int CNT_W     = 16;
  localparam int EV_W      = 3;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;

  // register values after reset
  localparam logic [CNT_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CNT_W-1:0] LONG_PRESS_RST = 16'd800;
  localparam logic [CNT_W-1:0] REPEAT_RST     = 16'd150;

  // per-key mode
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED  = 2'd2,
    MODE_LONG     = 2'd3
  } mode_t;

  // per-key event code
  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_LONG   = 3'd3,
    EV_REPEAT = 3'd4
  } event_t;

  // timing registers as seen by every lane
  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] repeat_ticks;
  } cfg_t;

endpackage

// File: rtl/core/kdlpr_lane.sv
// ---------------------------------------------------------------------------
// kdlpr_lane
// one key: edge detect, mode tracking and a shared countdown per tick
// ---------------------------------------------------------------------------
module kdlpr_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              level,
  input  kdlpr_pkg::cfg_t   cfg,
  output kdlpr_pkg::event_t ev
);
  import kdlpr_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             prev_r;
  logic             fell;
  logic             restart;
  logic             expired;

  // falling edge restarts the debounce only from idle or debouncing
  assign fell    = prev_r & ~level;
  assign restart = fell & ((mode_r == MODE_IDLE) | (mode_r == MODE_DEBOUNCE));
  assign expired = (cnt_r <= CNT_W'(1));

  // next mode and countdown
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    if (restart) begin
      mode_nxt = MODE_DEBOUNCE;
      cnt_nxt  = cfg.debounce_ticks;
    end else if (mode_r == MODE_IDLE) begin
      cnt_nxt = '0;
    end else if (!expired) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      case (mode_r)
        MODE_DEBOUNCE: begin
          if (!level) begin
            mode_nxt = MODE_PRESSED;
            cnt_nxt  = cfg.long_press_ticks;
          end else begin
            mode_nxt = MODE_IDLE;
            cnt_nxt  = '0;
          end
        end
        MODE_PRESSED, MODE_LONG: begin
          if (!level) begin
            mode_nxt = MODE_LONG;
            cnt_nxt  = cfg.repeat_ticks;
          end else begin
            mode_nxt = MODE_IDLE;
            cnt_nxt  = '0;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          cnt_nxt  = '0;
        end
      endcase
    end
  end

  // event of this tick, only on an expiry check
  always_comb begin
    ev = EV_NONE;
    if (!restart && (mode_r != MODE_IDLE) && expired) begin
      case (mode_r)
        MODE_DEBOUNCE: ev = level ? EV_NONE : EV_DOWN;
        MODE_PRESSED:  ev = level ? EV_UP   : EV_LONG;
        MODE_LONG:     ev = level ? EV_UP   : EV_REPEAT;
        default:       ev = EV_NONE;
      endcase
    end
  end

  // lane state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      prev_r <= 1'b1;
    end else if (step) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      prev_r <= level;
    end
  end

endmodule

// File: rtl/core/kdlpr_merge.sv
// ---------------------------------------------------------------------------
// kdlpr_merge
// packs the lane events into one result and holds it in a two-entry
// output buffer so a stalled sink does not stop the next tick
// ---------------------------------------------------------------------------
module kdlpr_merge #(
  parameter int NUM_KEYS = 2,
  localparam int OUT_W   = ((NUM_KEYS * kdlpr_pkg::EV_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kdlpr_pkg::event_t lane_ev [NUM_KEYS],
  output logic              space,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata
);
  import kdlpr_pkg::*;

  logic [OUT_W-1:0] packed_ev;
  logic [OUT_W-1:0] main_data_r, main_data_nxt;
  logic [OUT_W-1:0] skid_data_r, skid_data_nxt;
  logic             main_vld_r, main_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  logic             pop;

  // lane i lands in bits [3i+2:3i], padding stays zero
  always_comb begin
    packed_ev = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      packed_ev[i*EV_W +: EV_W] = lane_ev[i];
    end
  end

  assign pop = main_vld_r & out_tready;

  // buffer next state
  always_comb begin
    main_data_nxt = main_data_r;
    main_vld_nxt  = main_vld_r;
    skid_data_nxt = skid_data_r;
    skid_vld_nxt  = skid_vld_r;
    if (pop || !main_vld_r) begin
      main_data_nxt = skid_vld_r ? skid_data_r : packed_ev;
      main_vld_nxt  = skid_vld_r | push;
      skid_vld_nxt  = 1'b0;
    end else if (push) begin
      skid_data_nxt = packed_ev;
      skid_vld_nxt  = 1'b1;
    end
  end

  // control flags reset, payload free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space      = ~skid_vld_r;
  assign out_tvalid = main_vld_r;
  assign out_tdata  = main_data_r;

endmodule

// File: rtl/core/key_debounce_long_press_repeat_core.sv
// ---------------------------------------------------------------------------
// key_debounce_long_press_repeat_core
// Each input transaction is one time tick carrying the levels of NUM_KEYS
// active-low keys; each key has its own lane that debounces it and reports
// DOWN, LONG, REPEAT and UP events. One result transaction is produced per
// tick. A tick is taken every clock cycle while the output buffer has room;
// lane events are combinational and each result is registered. While the
// sink stalls, a two-entry output buffer takes one more tick and then holds
// the input off until its spare entry has moved on. The user must write the
// timing registers via the cfg port only while no tick is pending; the block does not check.
// ---------------------------------------------------------------------------
`include "key_debounce_long_press_repeat_core_macros.svh"

module key_debounce_long_press_repeat_core #(
  parameter int NUM_KEYS = 2,
  localparam int IN_W    = ((NUM_KEYS + 7) / 8) * 8,
  localparam int OUT_W   = ((NUM_KEYS * kdlpr_pkg::EV_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input tick stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_W-1:0]                  in_tdata,   // key1_level, key2_level, ...
  // event stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_W-1:0]                 out_tdata,  // key1_event[2:0], key2_event[5:3], ...
  // configuration writes
  input  logic                             cfg_we,
  input  logic [kdlpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdlpr_pkg::CNT_W-1:0]      cfg_wdata
);
  import kdlpr_pkg::*;

  cfg_t   cfg_r;
  event_t lane_ev [NUM_KEYS];
  logic   space;
  logic   step;

  // timing registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
      cfg_r.repeat_ticks     <= REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg_r.debounce_ticks   <= cfg_wdata;
        CFG_LONG_PRESS: cfg_r.long_press_ticks <= cfg_wdata;
        CFG_REPEAT:     cfg_r.repeat_ticks     <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // a tick advances every lane when the buffer has room
  assign in_tready = space;
  assign step      = in_tvalid & in_tready;

  // one lane per key
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    kdlpr_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (step),
      .level (in_tdata[g]),
      .cfg   (cfg_r),
      .ev    (lane_ev[g])
    );
  end

  // event packing and output buffer
  kdlpr_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .lane_ev    (lane_ev),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // an accepted tick always leaves a result behind
  `KDLPR_ASSERT_NEXT(a_tick_gives_result, step, out_tvalid)
  // the spare entry only fills behind a held result
  `KDLPR_ASSERT_SAME(a_skid_behind_main, !in_tready, out_tvalid)
  // first key never reports an undefined event code
  `KDLPR_ASSERT_SAME(a_ev_code_range, out_tvalid, out_tdata[2:0] <= EV_REPEAT)

endmodule
